### src/sfl_pkg.sv
package sfl_pkg;

    typedef enum logic [1:0] {
        CLS_IGN = 2'd0,
        CLS_NEG = 2'd1,
        CLS_POS = 2'd2
    } t_cls;

    typedef struct packed {
        logic [15:0] logit;
        t_cls        cls;
    } t_qitem;

    typedef logic [15:0][30:0] t_ctab;

    localparam logic [2:0] REG_ALPHA  = 3'd0;
    localparam logic [2:0] REG_GAMMA  = 3'd1;
    localparam logic [2:0] REG_OFFSET = 3'd2;
    localparam logic [2:0] REG_NCLS   = 3'd3;
    localparam logic [2:0] REG_NSPAT  = 3'd4;

    localparam int          CFG_DW    = 21;
    localparam logic [31:0] ONE_Q30   = 32'd1 << 30;
    localparam logic [63:0] HALF_Q30  = 64'd1 << 29;
    localparam logic [31:0] LOG2E_Q30 = 32'd1549082005;
    localparam logic [31:0] LN2_Q30   = 32'd744261118;
    localparam logic [23:0] LOSS_MAX  = 24'hFFFFFF;

    function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
        logic [63:0] n;
        logic [63:0] r;
        logic [63:0] b;
        n = n_in;
        r = '0;
        b = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // entry k is the factor 2^-(2^(k-16)) in Q30, for fraction bit k
    function automatic t_ctab build_ctab();
        t_ctab       tab;
        logic [63:0] c;
        c = isqrt64(64'd1 << 59);
        for (int j = 15; j >= 0; j--) begin
            tab[j] = c[30:0];
            c = isqrt64(c << 30);
        end
        return tab;
    endfunction

    localparam t_ctab EXP_TAB = build_ctab();

endpackage

### src/sfl_fifo.sv
module sfl_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  sfl_pkg::t_qitem i_data,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output sfl_pkg::t_qitem o_data
);
    sfl_pkg::t_qitem r_mem [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;

    assign o_full  = (r_cnt == 3'd4);
    assign o_valid = (r_cnt != 3'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wp] <= i_data;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push && !o_full) r_wp <= r_wp + 2'd1;
            if (i_pop && o_valid) r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + {2'd0, i_push && !o_full} - {2'd0, i_pop && o_valid};
        end
    end
endmodule

### src/sfl_front.sv
module sfl_front #(
    parameter int MAX_CLASSES = 4096,
    parameter int MAX_SPATIAL = 1048576
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [15:0]     i_logit,
    input  logic [15:0]     i_target_label,
    input  logic            i_last_item,
    input  logic [14:0]     i_class_offset,
    input  logic [12:0]     i_num_classes,
    input  logic [20:0]     i_spatial_size,
    input  logic            i_q_full,
    output logic            o_push,
    output sfl_pkg::t_qitem o_item
);
    localparam int CW = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
    localparam int SW = (MAX_SPATIAL > 1) ? $clog2(MAX_SPATIAL) : 1;

    logic [CW-1:0] r_cpos;
    logic [SW-1:0] r_spos;
    logic [31:0]   nc, ns, label, tgt_u;
    logic          take;

    assign o_ready = !i_q_full;
    assign take    = i_valid && o_ready;
    assign o_push  = take;

    always_comb begin
        nc = {19'd0, i_num_classes};
        if (nc == 32'd0) nc = 32'd1;
        else if (nc > 32'(MAX_CLASSES)) nc = 32'(MAX_CLASSES);
        ns = {11'd0, i_spatial_size};
        if (ns == 32'd0) ns = 32'd1;
        else if (ns > 32'(MAX_SPATIAL)) ns = 32'(MAX_SPATIAL);
        label = 32'(r_cpos) + {17'd0, i_class_offset};
        tgt_u = {16'd0, i_target_label};
        o_item.logit = i_logit;
        if (i_target_label[15]) o_item.cls = sfl_pkg::CLS_IGN;
        else if (tgt_u == label) o_item.cls = sfl_pkg::CLS_POS;
        else o_item.cls = sfl_pkg::CLS_NEG;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpos <= '0;
            r_spos <= '0;
        end else if (take) begin
            if (i_last_item) begin
                r_cpos <= '0;
                r_spos <= '0;
            end else if (32'(r_spos) + 32'd1 >= ns) begin
                r_spos <= '0;
                r_cpos <= (32'(r_cpos) + 32'd1 >= nc) ? '0 : r_cpos + 1'b1;
            end else begin
                r_spos <= r_spos + 1'b1;
            end
        end
    end
endmodule

### src/sfl_back.sv
module sfl_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  sfl_pkg::t_qitem i_q_data,
    output logic            o_q_pop,
    input  logic [16:0]     i_alpha_weight,
    input  logic [15:0]     i_focus_exponent,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [23:0]     o_loss_value,
    output logic            o_positive_mask
);
    typedef enum logic [3:0] {
        ST_IDLE, ST_Y, ST_EXP, ST_SH, ST_LN, ST_LNS, ST_T, ST_W, ST_R, ST_OUT
    } t_state;

    t_state        r_state;
    logic          r_phase, r_neg, r_pos, r_ovalid, r_mask;
    sfl_pkg::t_cls r_cls;
    logic [16:0]   r_aq, r_lg, r_q;
    logic [27:0]   r_t;
    logic [12:0]   r_n;
    logic [15:0]   r_f;
    logic [30:0]   r_v;
    logic [31:0]   r_z;
    logic [3:0]    r_k;
    logic [22:0]   r_ex, r_s;
    logic [23:0]   r_res, r_loss;

    logic [31:0] mul_a, mul_b;
    logic [63:0] prod, rnd30;
    logic [16:0] alpha_c, weight, absx, lse;
    logic [31:0] vsh, z0;
    logic [32:0] sq;
    logic [22:0] sn, sp;
    logic [47:0] rr;

    assign o_q_pop         = (r_state == ST_IDLE) && i_q_valid;
    assign o_valid         = r_ovalid;
    assign o_loss_value    = r_loss;
    assign o_positive_mask = r_mask;

    always_comb begin
        alpha_c = (i_alpha_weight > 17'd65536) ? 17'd65536 : i_alpha_weight;
        weight  = (r_cls == sfl_pkg::CLS_POS) ? alpha_c : 17'd65536 - alpha_c;
        absx    = i_q_data.logit[15] ? 17'd0 - {1'b1, i_q_data.logit}
                                     : {1'b0, i_q_data.logit};
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            ST_Y:   begin mul_a = {4'd0, r_t};     mul_b = sfl_pkg::LOG2E_Q30;           end
            ST_EXP: begin mul_a = {1'b0, r_v};     mul_b = {1'b0, sfl_pkg::EXP_TAB[r_k]}; end
            ST_LN:  begin mul_a = r_z;             mul_b = r_z;                          end
            ST_LNS: begin mul_a = {15'd0, r_lg};   mul_b = sfl_pkg::LN2_Q30;             end
            ST_T:   begin mul_a = {16'd0, i_focus_exponent}; mul_b = {9'd0, r_ex};       end
            ST_W:   begin mul_a = {15'd0, weight}; mul_b = {1'b0, r_v};                  end
            ST_R:   begin mul_a = {15'd0, r_q};    mul_b = {9'd0, r_s};                  end
            default: ;
        endcase
        prod  = mul_a * mul_b;
        rnd30 = (prod + sfl_pkg::HALF_Q30) >> 30;
        if (r_n >= 13'd32) vsh = '0;
        else if (r_n == 13'd0) vsh = {1'b0, r_v};
        else vsh = ({1'b0, r_v} + (32'd1 << (r_n[4:0] - 5'd1))) >> r_n[4:0];
        z0  = sfl_pkg::ONE_Q30 + vsh;
        sq  = rnd30[32:0];
        lse = rnd30[16:0];
        sn  = (r_neg ? {r_aq, 6'd0} : 23'd0) + {6'd0, lse};
        sp  = (r_pos ? {r_aq, 6'd0} : 23'd0) + {6'd0, lse};
        rr  = (prod[47:0] + 48'd32768) >> 16;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_ready && (r_state != ST_OUT)) r_ovalid <= 1'b0;
            unique case (r_state)
                ST_IDLE: if (i_q_valid) begin
                    r_cls   <= i_q_data.cls;
                    r_neg   <= i_q_data.logit[15];
                    r_pos   <= !i_q_data.logit[15] && (i_q_data.logit != 16'd0);
                    r_aq    <= absx;
                    r_t     <= {5'd0, absx, 6'd0};
                    r_phase <= 1'b0;
                    r_res   <= '0;
                    r_state <= (i_q_data.cls == sfl_pkg::CLS_IGN) ? ST_OUT : ST_Y;
                end
                ST_Y: begin
                    r_n     <= rnd30[28:16];
                    r_f     <= rnd30[15:0];
                    r_v     <= sfl_pkg::ONE_Q30[30:0];
                    r_k     <= 4'd15;
                    r_state <= ST_EXP;
                end
                ST_EXP: begin
                    if (r_f[r_k]) r_v <= rnd30[30:0];
                    r_k <= r_k - 4'd1;
                    if (r_k == 4'd0) r_state <= ST_SH;
                end
                ST_SH: begin
                    r_v <= vsh[30:0];
                    r_k <= 4'd15;
                    if (r_phase) begin
                        r_state <= ST_W;
                    end else begin
                        if (z0 >= {sfl_pkg::ONE_Q30[30:0], 1'b0}) begin
                            r_lg <= 17'h10000;
                            r_z  <= z0 >> 1;
                        end else begin
                            r_lg <= '0;
                            r_z  <= z0;
                        end
                        r_state <= ST_LN;
                    end
                end
                ST_LN: begin
                    if (sq >= {1'b0, sfl_pkg::ONE_Q30[30:0], 1'b0}) begin
                        r_lg[r_k] <= 1'b1;
                        r_z       <= sq[32:1];
                    end else begin
                        r_z <= sq[31:0];
                    end
                    r_k <= r_k - 4'd1;
                    if (r_k == 4'd0) r_state <= ST_LNS;
                end
                ST_LNS: begin
                    r_ex    <= (r_cls == sfl_pkg::CLS_POS) ? sp : sn;
                    r_s     <= (r_cls == sfl_pkg::CLS_POS) ? sn : sp;
                    r_state <= ST_T;
                end
                ST_T: begin
                    r_t     <= 28'((prod + 64'd2048) >> 12);
                    r_phase <= 1'b1;
                    r_state <= ST_Y;
                end
                ST_W: begin
                    r_q     <= rnd30[16:0];
                    r_state <= ST_R;
                end
                ST_R: begin
                    r_res   <= (rr > {24'd0, sfl_pkg::LOSS_MAX}) ? sfl_pkg::LOSS_MAX : rr[23:0];
                    r_state <= ST_OUT;
                end
                ST_OUT: if (!r_ovalid || i_ready) begin
                    r_loss   <= r_res;
                    r_mask   <= (r_cls == sfl_pkg::CLS_POS);
                    r_ovalid <= 1'b1;
                    r_state  <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end
endmodule

### src/sigmoid_focal_loss.sv
// Sigmoid focal loss, one logit per item in batch, class, spatial order.
// Input channel: i_in_valid/o_in_ready with i_logit (Q6.10), i_target_label
// and i_last_item. Output channel: o_out_valid/i_out_ready with
// o_loss_value (Q8.16, saturating) and o_positive_mask, one per input item.
// Config: i_cfg_wr_en writes i_cfg_wdata to register i_cfg_addr
// (0 alpha, 1 gamma, 2 class offset, 3 class count, 4 spatial size);
// write only while idle.
// The front end classifies each item against the class/spatial counters and
// queues it (4 entries). The back end runs all arithmetic on one shared
// 32x32 multiplier: an ignored item goes straight to output; any other
// takes two 16-step exp passes and a 16-step log pass plus 10 single steps.
// The back end takes a new item from the queue only once it has handed the
// last one to the output.
// Reset (synchronous, active low) clears counters, queue and output valid,
// and loads register defaults. When the receiver stalls the result holds,
// the back end waits, and the queue fills until o_in_ready drops.
module sigmoid_focal_loss #(
    parameter int MAX_CLASSES = 4096,
    parameter int MAX_SPATIAL = 1048576
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [2:0]                 i_cfg_addr,
    input  logic [sfl_pkg::CFG_DW-1:0] i_cfg_wdata,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic signed [15:0]         i_logit,
    input  logic signed [15:0]         i_target_label,
    input  logic                       i_last_item,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [23:0]                o_loss_value,
    output logic                       o_positive_mask
);
    logic [16:0] r_alpha;
    logic [15:0] r_gamma;
    logic [14:0] r_offset;
    logic [12:0] r_ncls;
    logic [20:0] r_nspat;

    logic            q_push, q_full, q_pop, q_valid;
    sfl_pkg::t_qitem q_in, q_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha  <= 17'd16384;
            r_gamma  <= 16'd8192;
            r_offset <= '0;
            r_ncls   <= 13'd1;
            r_nspat  <= 21'd1;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                sfl_pkg::REG_ALPHA:  r_alpha  <= i_cfg_wdata[16:0];
                sfl_pkg::REG_GAMMA:  r_gamma  <= i_cfg_wdata[15:0];
                sfl_pkg::REG_OFFSET: r_offset <= i_cfg_wdata[14:0];
                sfl_pkg::REG_NCLS:   r_ncls   <= i_cfg_wdata[12:0];
                sfl_pkg::REG_NSPAT:  r_nspat  <= i_cfg_wdata[20:0];
                default: ;
            endcase
        end
    end

    sfl_front #(.MAX_CLASSES(MAX_CLASSES), .MAX_SPATIAL(MAX_SPATIAL)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_in_valid), .o_ready(o_in_ready),
        .i_logit(i_logit), .i_target_label(i_target_label), .i_last_item(i_last_item),
        .i_class_offset(r_offset), .i_num_classes(r_ncls), .i_spatial_size(r_nspat),
        .i_q_full(q_full), .o_push(q_push), .o_item(q_in)
    );

    sfl_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(q_push), .i_data(q_in), .o_full(q_full),
        .i_pop(q_pop), .o_valid(q_valid), .o_data(q_out)
    );

    sfl_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_q_valid(q_valid), .i_q_data(q_out), .o_q_pop(q_pop),
        .i_alpha_weight(r_alpha), .i_focus_exponent(r_gamma),
        .o_valid(o_out_valid), .i_ready(i_out_ready),
        .o_loss_value(o_loss_value), .o_positive_mask(o_positive_mask)
    );
endmodule

### src/sfl_checker.sv
module sfl_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [23:0] o_loss_value
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_loss_value))
        else $error("output item dropped or changed while stalled");

    a_rst_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_rst_in: assert property (@(posedge i_clk) !i_rst_n |=> o_in_ready)
        else $error("input not ready after reset");
endmodule

bind sigmoid_focal_loss sfl_checker u_sfl_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_in_ready(o_in_ready),
    .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_loss_value(o_loss_value)
);
